// ===== rtl/sensor_frame_deframer_crc8_top_macros.svh =====
// Assertion macros shared by the sensor frame deframer RTL.
// Depends on nothing; the using module provides clk and rst.
`ifndef SENSOR_FRAME_DEFRAMER_CRC8_TOP_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_CRC8_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be true.
`define SFD_ASSERT_NEVER(lbl, cond, msg) \
  `SFD_ASSERT(lbl, !(cond), msg)
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/sfd_pkg.sv =====
// Shared types, constants and the CRC-8 step for the sensor frame deframer.
// Used by every module of the block; depends on nothing.
package sfd_pkg;

  // Record store size and the widths that follow from it.
  localparam int MAX_RECORDS = 8;
  localparam int REC_AW      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Command queue between the parser and the emitter.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // CRC-8 polynomial and top bit.
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // Frame status codes.
  localparam logic [1:0] FS_OK     = 2'd0;
  localparam logic [1:0] FS_CRC    = 2'd1;
  localparam logic [1:0] FS_NO_END = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_MARKER = 3'd0;
  localparam logic [2:0] CFG_END_MARKER   = 3'd1;
  localparam logic [2:0] CFG_SENSOR_COUNT = 3'd2;
  localparam logic [2:0] CFG_TEMP_LOW     = 3'd3;
  localparam logic [2:0] CFG_TEMP_HIGH    = 3'd4;

  // Current register contents.
  typedef struct packed {
    logic [7:0]         start_marker;
    logic [7:0]         end_marker;
    logic [2:0]         sensor_count;
    logic signed [15:0] temp_low_limit;
    logic signed [15:0] temp_high_limit;
  } cfg_t;

  // One end-of-frame command: status and number of records to emit.
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // Write port of the record store.
  typedef struct packed {
    logic              en;
    logic [REC_AW-1:0] addr;
    logic [23:0]       data;
  } rec_wr_t;

  // One byte through the CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfd_front.sv =====
// Frame parser: hunts for the start byte, checks the CRC, assembles records.
// Depends on sfd_pkg; feeds sfd_cmdq and the record store in sfd_back.
module sfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  sfd_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 q_full,
  input  logic                 back_busy,
  output logic                 q_push,
  output sfd_pkg::cmd_t        q_cmd,
  output sfd_pkg::rec_wr_t     rec_wr
);

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC     = 5'b01000,
    PH_END     = 5'b10000
  } phase_t;

  phase_t     phase;
  logic [7:0] plen;
  logic [7:0] pos;
  logic [7:0] crc;
  logic [7:0] rx_crc;
  logic [7:0] declared;
  logic [1:0] part;
  logic [6:0] rec_idx;
  logic [7:0] id_hold;
  logic [7:0] hi_hold;

  logic       accept;
  logic [7:0] pos_inc;
  logic [7:0] sc_lim;
  logic [7:0] n0;
  logic [7:0] n1;
  logic [7:0] n2;
  logic [1:0] status;

  // The record store is shared with the emitter, so payload waits for it.
  assign in_stall = ((phase == PH_END) && q_full) || ((phase == PH_PAYLOAD) && back_busy);
  assign accept   = in_valid && !in_stall;
  assign pos_inc  = pos + 8'd1;

  // Record count clamp: declared, sensors plus one, store size, complete records.
  always_comb begin
    sc_lim = {5'd0, cfg.sensor_count} + 8'd1;
    n0     = (declared < sc_lim) ? declared : sc_lim;
    n1     = (n0 < 8'(sfd_pkg::MAX_RECORDS)) ? n0 : 8'(sfd_pkg::MAX_RECORDS);
    n2     = (n1 < {1'b0, rec_idx}) ? n1 : {1'b0, rec_idx};
  end

  // End byte decides the status; a missing end byte wins over a CRC error.
  always_comb begin
    if (rx_byte != cfg.end_marker) begin
      status = sfd_pkg::FS_NO_END;
    end else if (crc != rx_crc) begin
      status = sfd_pkg::FS_CRC;
    end else begin
      status = sfd_pkg::FS_OK;
    end
  end

  assign q_push       = accept && (phase == PH_END);
  assign q_cmd.status = status;
  assign q_cmd.count  = (status == sfd_pkg::FS_OK) ? n2[sfd_pkg::CNT_W-1:0] : '0;

  // A record is written whole when its low temperature byte arrives.
  assign rec_wr.en   = accept && (phase == PH_PAYLOAD) && (pos != 8'd0) && (part == 2'd2)
                       && (rec_idx < 7'(sfd_pkg::MAX_RECORDS));
  assign rec_wr.addr = rec_idx[sfd_pkg::REC_AW-1:0];
  assign rec_wr.data = {id_hold, hi_hold, rx_byte};

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      plen     <= 8'd0;
      pos      <= 8'd0;
      crc      <= 8'd0;
      rx_crc   <= 8'd0;
      declared <= 8'd0;
      part     <= 2'd0;
      rec_idx  <= 7'd0;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.start_marker) begin
            phase <= PH_LEN;
          end
        end
        PH_LEN: begin
          plen     <= rx_byte;
          pos      <= 8'd0;
          crc      <= 8'd0;
          declared <= 8'd0;
          part     <= 2'd0;
          rec_idx  <= 7'd0;
          phase    <= (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc <= sfd_pkg::crc8_step(crc, rx_byte);
          if (pos == 8'd0) begin
            declared <= rx_byte;
          end else if (part == 2'd2) begin
            part    <= 2'd0;
            rec_idx <= rec_idx + 7'd1;
          end else begin
            part <= part + 2'd1;
          end
          pos <= pos_inc;
          if (pos_inc >= plen) begin
            phase <= PH_CRC;
          end
        end
        PH_CRC: begin
          rx_crc <= rx_byte;
          phase  <= PH_END;
        end
        PH_END: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

  // Holding registers for the id and high temperature byte.
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_PAYLOAD) && (pos != 8'd0)) begin
      if (part == 2'd0) begin
        id_hold <= rx_byte;
      end
      if (part == 2'd1) begin
        hi_hold <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/sfd_cmdq.sv =====
// Two-entry queue of end-of-frame commands between parser and emitter.
// Depends on sfd_pkg and the assertion macro header.
`include "sensor_frame_deframer_crc8_top_macros.svh"
module sfd_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sfd_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  sfd_pkg::cmd_t              entries [sfd_pkg::QDEPTH];
  logic [sfd_pkg::QAW-1:0]    wr_ptr;
  logic [sfd_pkg::QAW-1:0]    rd_ptr;
  logic [sfd_pkg::QAW:0]      count;

  assign full    = (count == (sfd_pkg::QAW + 1)'(sfd_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `SFD_ASSERT_NEVER(a_no_push_full, push && full, "command pushed into a full queue")
  `SFD_ASSERT_NEVER(a_no_pop_empty, pop && empty, "command popped from an empty queue")

endmodule

// ===== rtl/sfd_back.sv =====
// Emitter: turns end-of-frame commands into record and status items.
// Depends on sfd_pkg and the assertion macro header; holds the record store.
`include "sensor_frame_deframer_crc8_top_macros.svh"
module sfd_back (
  input  logic                clk,
  input  logic                rst,
  input  sfd_pkg::cfg_t       cfg,
  input  sfd_pkg::rec_wr_t    rec_wr,
  input  logic                q_empty,
  input  sfd_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_status,
  output logic [7:0]          sensor_id,
  output logic signed [15:0]  centi_temp,
  output logic                out_of_range,
  output logic [1:0]          frame_status,
  output logic [3:0]          records_emitted,
  output logic                last
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RD   = 4'b0010,
    B_REC  = 4'b0100,
    B_STAT = 4'b1000
  } bstate_t;

  bstate_t                     state;
  sfd_pkg::cmd_t               cur;
  logic [sfd_pkg::CNT_W-1:0]   idx;
  logic [sfd_pkg::CNT_W-1:0]   idx_inc;
  logic [23:0]                 store [sfd_pkg::MAX_RECORDS];
  logic [23:0]                 rd_data;
  logic signed [15:0]          rd_temp;
  logic                        rd_oor;
  logic                        slot_free;
  logic                        load_rec;
  logic                        load_stat;

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign busy      = (state != B_IDLE) || !q_empty;
  assign slot_free = !out_valid || !out_stall;
  assign load_rec  = (state == B_REC) && slot_free;
  assign load_stat = (state == B_STAT) && slot_free;
  assign idx_inc   = idx + 1'b1;
  assign rd_temp   = signed'(rd_data[15:0]);
  assign rd_oor    = (rd_temp < cfg.temp_low_limit) || (rd_temp > cfg.temp_high_limit);

  // Record store: written by the parser, read here one entry at a time.
  always_ff @(posedge clk) begin
    if (rec_wr.en) begin
      store[rec_wr.addr] <= rec_wr.data;
    end
    rd_data <= store[idx[sfd_pkg::REC_AW-1:0]];
  end

  // Emission sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            idx <= '0;
            if ((q_cmd.status != sfd_pkg::FS_OK) || (q_cmd.count == '0)) begin
              state <= B_STAT;
            end else begin
              state <= B_RD;
            end
          end
        end
        B_RD: begin
          state <= B_REC;
        end
        B_REC: begin
          if (slot_free) begin
            idx   <= idx_inc;
            state <= (idx_inc == cur.count) ? B_STAT : B_RD;
          end
        end
        B_STAT: begin
          if (slot_free) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Current command.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_rec || load_stat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rec) begin
      is_status       <= 1'b0;
      sensor_id       <= rd_data[23:16];
      centi_temp      <= rd_temp;
      out_of_range    <= rd_oor;
      frame_status    <= sfd_pkg::FS_OK;
      records_emitted <= 4'd0;
      last            <= 1'b0;
    end else if (load_stat) begin
      is_status       <= 1'b1;
      sensor_id       <= 8'd0;
      centi_temp      <= 16'sd0;
      out_of_range    <= 1'b0;
      frame_status    <= cur.status;
      records_emitted <= 4'(cur.count);
      last            <= 1'b1;
    end
  end

  `SFD_ASSERT(a_rec_in_range, (state == B_REC) |-> (idx < cur.count),
              "record index past the frame's record count")
  `SFD_ASSERT(a_rec_only_ok, load_rec |-> (cur.status == sfd_pkg::FS_OK),
              "record emitted for a bad frame")
  `SFD_ASSERT(a_out_held, (out_valid && out_stall) |=> $stable(last) && out_valid,
              "stalled result changed")

endmodule

// ===== rtl/sensor_frame_deframer_crc8_top.sv =====
// Top level of the framed sensor report parser with CRC-8 check.
// Depends on sfd_pkg, sfd_front, sfd_cmdq and sfd_back.
//
// The parser takes one received byte per cycle. Frames are start byte, length,
// payload, CRC-8 (poly 0x07, init 0, over the payload) and end byte; the payload
// is a record count and three-byte records of id and signed centi-degree
// temperature. At the end byte the frame's command enters a two-entry queue and
// the emitter delivers each record by a store read and then an output register
// load, followed by one status item. Input is stalled during a payload while the
// previous frame's records are still going out, since both use one record
// store, and at an end byte while the command queue is full. Configuration
// writes are always taken; the record store needs no clearing after reset.
module sensor_frame_deframer_crc8_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_status,
  output logic [7:0]         sensor_id,
  output logic signed [15:0] centi_temp,
  output logic               out_of_range,
  output logic [1:0]         frame_status,
  output logic [3:0]         records_emitted,
  output logic               last
);

  sfd_pkg::cfg_t    cfg;
  sfd_pkg::cmd_t    push_cmd;
  sfd_pkg::cmd_t    pop_cmd;
  sfd_pkg::rec_wr_t rec_wr;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             back_busy;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= 8'd2;
      cfg.end_marker      <= 8'd3;
      cfg.sensor_count    <= 3'd6;
      cfg.temp_low_limit  <= -16'sd4000;
      cfg.temp_high_limit <= 16'sd8500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfd_pkg::CFG_START_MARKER: cfg.start_marker    <= cfg_data[7:0];
        sfd_pkg::CFG_END_MARKER:   cfg.end_marker      <= cfg_data[7:0];
        sfd_pkg::CFG_SENSOR_COUNT: cfg.sensor_count    <= cfg_data[2:0];
        sfd_pkg::CFG_TEMP_LOW:     cfg.temp_low_limit  <= signed'(cfg_data);
        sfd_pkg::CFG_TEMP_HIGH:    cfg.temp_high_limit <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .back_busy (back_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .rec_wr    (rec_wr)
  );

  sfd_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .rec_wr          (rec_wr),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .busy            (back_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_status       (is_status),
    .sensor_id       (sensor_id),
    .centi_temp      (centi_temp),
    .out_of_range    (out_of_range),
    .frame_status    (frame_status),
    .records_emitted (records_emitted),
    .last            (last)
  );

endmodule

// ===== bench/tb_sensor_frame_deframer_crc8_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the framed sensor report parser with CRC-8 check.
// Depends on sfd_pkg and sensor_frame_deframer_crc8_top; predicts every output
// transaction from the bytes it sends and compares each one field by field.
module tb_sensor_frame_deframer_crc8_top;

  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_PRINTS    = 60;
  localparam longint TIMEOUT_NS = 2_000_000;

  // Parser phases of the predictor.
  typedef enum logic [4:0] {
    SEEK_START  = 5'b00001,
    GET_LENGTH  = 5'b00010,
    GET_PAYLOAD = 5'b00100,
    GET_CRC     = 5'b01000,
    GET_END     = 5'b10000
  } parse_phase_t;

  // One expected output transaction.
  typedef struct packed {
    logic               is_status;
    logic [7:0]         sensor_id;
    logic signed [15:0] centi_temp;
    logic               out_of_range;
    logic [1:0]         frame_status;
    logic [3:0]         records_emitted;
    logic               last_item;
  } frame_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_status;
  logic [7:0]         sensor_id;
  logic signed [15:0] centi_temp;
  logic               out_of_range;
  logic [1:0]         frame_status;
  logic [3:0]         records_emitted;
  logic               last;

  sensor_frame_deframer_crc8_top uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_status       (is_status),
    .sensor_id       (sensor_id),
    .centi_temp      (centi_temp),
    .out_of_range    (out_of_range),
    .frame_status    (frame_status),
    .records_emitted (records_emitted),
    .last            (last)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers and the parser state.
  logic [7:0]         m_start;
  logic [7:0]         m_end;
  logic [2:0]         m_sensors;
  logic signed [15:0] m_low;
  logic signed [15:0] m_high;
  parse_phase_t       m_phase;
  logic [7:0]         m_len;
  logic [7:0]         m_pos;
  logic [7:0]         m_crc;
  logic [7:0]         m_rx_crc;
  logic [7:0]         m_declared;
  logic [23:0]        m_store [sfd_pkg::MAX_RECORDS];

  frame_item_t expected_items [$];
  logic [7:0]  frame_body [$];
  int          parsed_bytes = 0;
  int          mismatches = 0;
  bit          gaps_on = 1'b1;
  int          burst_left = 0;
  int          hold_requests = 0;

  // Receiver side state.
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_cycle = 0;
  int          stall_mode = 0;

  // CRC-8, polynomial 0x07, MSB first, over one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ sfd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void reset_predictor();
    m_start    = 8'd2;
    m_end      = 8'd3;
    m_sensors  = 3'd6;
    m_low      = -16'sd4000;
    m_high     = 16'sd8500;
    m_phase    = SEEK_START;
    m_len      = '0;
    m_pos      = '0;
    m_crc      = '0;
    m_rx_crc   = '0;
    m_declared = '0;
    for (int i = 0; i < sfd_pkg::MAX_RECORDS; i++) m_store[i] = '0;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      sfd_pkg::CFG_START_MARKER: m_start = data[7:0];
      sfd_pkg::CFG_END_MARKER:   m_end = data[7:0];
      sfd_pkg::CFG_SENSOR_COUNT: m_sensors = data[2:0];
      sfd_pkg::CFG_TEMP_LOW:     m_low = data;
      sfd_pkg::CFG_TEMP_HIGH:    m_high = data;
      default: ;
    endcase
  endfunction

  // Advance the parser copy by one accepted byte and queue what it causes.
  function automatic void track_rx_byte(input logic [7:0] b);
    int          off;
    int          rec;
    int          part;
    int          n;
    int          complete;
    logic signed [15:0] t;
    frame_item_t it;
    if (m_phase != SEEK_START || b == m_start) parsed_bytes++;
    case (m_phase)
      SEEK_START: begin
        if (b == m_start) m_phase = GET_LENGTH;
      end
      GET_LENGTH: begin
        m_len      = b;
        m_pos      = '0;
        m_crc      = '0;
        m_declared = '0;
        m_phase    = (b == 8'd0) ? GET_CRC : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        m_crc = crc8_update(m_crc, b);
        if (m_pos == 8'd0) begin
          m_declared = b;
        end else begin
          off  = int'(m_pos) - 1;
          rec  = off / 3;
          part = off % 3;
          // Bytes of records past the store still count toward the CRC only.
          if (rec < sfd_pkg::MAX_RECORDS) m_store[rec][(23 - 8 * part) -: 8] = b;
        end
        m_pos = m_pos + 8'd1;
        if (m_pos >= m_len) m_phase = GET_CRC;
      end
      GET_CRC: begin
        m_rx_crc = b;
        m_phase  = GET_END;
      end
      default: begin
        m_phase = SEEK_START;
        it = '0;
        it.is_status = 1'b1;
        it.last_item = 1'b1;
        // A wrong end byte wins over a CRC error.
        if (b != m_end) begin
          it.frame_status = sfd_pkg::FS_NO_END;
          expected_items.push_back(it);
        end else if (m_crc != m_rx_crc) begin
          it.frame_status = sfd_pkg::FS_CRC;
          expected_items.push_back(it);
        end else begin
          n = int'(m_declared);
          if (n > int'(m_sensors) + 1) n = int'(m_sensors) + 1;
          if (n > sfd_pkg::MAX_RECORDS) n = sfd_pkg::MAX_RECORDS;
          complete = (m_len == 8'd0) ? 0 : (int'(m_len) - 1) / 3;
          if (n > complete) n = complete;
          for (int i = 0; i < n; i++) begin
            t = m_store[i][15:0];
            it = '0;
            it.sensor_id    = m_store[i][23:16];
            it.centi_temp   = t;
            it.out_of_range = (t < m_low) || (t > m_high);
            expected_items.push_back(it);
          end
          it = '0;
          it.is_status       = 1'b1;
          it.frame_status    = sfd_pkg::FS_OK;
          it.records_emitted = n[3:0];
          it.last_item       = 1'b1;
          expected_items.push_back(it);
        end
      end
    endcase
  endfunction

  // Offer one byte, idling between bursts, and wait for its transaction.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
  endtask

  // Write all five registers back to back and mirror them in the predictor.
  task automatic write_settings(input logic [7:0] sm, input logic [7:0] em,
                                input logic [2:0] sc, input logic signed [15:0] lo,
                                input logic signed [15:0] hi);
    logic [15:0] values [5];
    values[sfd_pkg::CFG_START_MARKER] = {8'h00, sm};
    values[sfd_pkg::CFG_END_MARKER]   = {8'h00, em};
    values[sfd_pkg::CFG_SENSOR_COUNT] = {13'h0000, sc};
    values[sfd_pkg::CFG_TEMP_LOW]     = lo;
    values[sfd_pkg::CFG_TEMP_HIGH]    = hi;
    for (int i = 0; i <= sfd_pkg::CFG_TEMP_HIGH; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= values[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_register(i[2:0], values[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected transaction has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_temp();
    case ($urandom_range(0, 7))
      0: return m_low - 16'sd1;
      1: return m_low;
      2: return m_high;
      3: return m_high + 16'sd1;
      4: return 16'h8000;
      5: return 16'h7FFF;
      6: return 16'h0000;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic add_record(input logic [7:0] id, input logic [15:0] temp);
    frame_body.push_back(id);
    frame_body.push_back(temp[15:8]);
    frame_body.push_back(temp[7:0]);
  endtask

  // Send the frame held in frame_body; keep >= 0 cuts it after that many body bytes.
  task automatic send_frame(input bit bad_crc, input bit bad_end, input int keep);
    logic [7:0] crc;
    logic [7:0] tail;
    crc = '0;
    send_byte(m_start);
    send_byte(8'(frame_body.size()));
    foreach (frame_body[i]) begin
      if (keep >= 0 && i >= keep) begin
        frame_body.delete();
        return;
      end
      crc = crc8_update(crc, frame_body[i]);
      send_byte(frame_body[i]);
    end
    frame_body.delete();
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(crc);
    tail = m_end;
    if (bad_end) tail = tail ^ 8'($urandom_range(1, 255));
    send_byte(tail);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == m_start) b = 8'($urandom_range(0, 255));
    send_byte(b);
  endtask

  // Mostly well-formed frames with random content, some corrupted or cut short.
  task automatic send_random_frame();
    int         nrec;
    int         extra;
    int         declared;
    int         roll;
    int         keep;
    logic [7:0] id;
    nrec  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 9);
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    roll  = $urandom_range(0, 9);
    if (roll < 6) declared = nrec;
    else if (roll < 8) declared = $urandom_range(0, nrec + 2);
    else declared = $urandom_range(0, 255);
    repeat ($urandom_range(0, 2)) send_noise();
    if ($urandom_range(0, 11) != 0) begin
      frame_body.push_back(declared[7:0]);
      repeat (nrec) begin
        id = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        add_record(id, pick_temp());
      end
      repeat (extra) frame_body.push_back(8'($urandom_range(0, 255)));
    end
    keep = ($urandom_range(0, 14) == 0) ? $urandom_range(0, frame_body.size()) : -1;
    send_frame($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, keep);
  endtask

  // Feed bytes until the parser is back to hunting for a start byte.
  task automatic close_frame();
    while (m_phase != SEEK_START) begin
      if (m_phase == GET_END) send_byte(m_end);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_segment(input int target);
    int first;
    first = parsed_bytes;
    while (parsed_bytes - first < target) send_random_frame();
    close_frame();
    wait_idle();
  endtask

  // Reset register values, noise, zero length, clamp by complete records, errors.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b0, 1'b0, -1);
    frame_body.push_back(8'hFF);
    add_record(8'hFF, 16'h8000);
    send_frame(1'b0, 1'b0, -1);
    send_frame(1'b1, 1'b0, -1);
    send_frame(1'b0, 1'b1, -1);
    send_frame(1'b1, 1'b1, -1);
    wait_idle();
  endtask

  // Register extremes: every record in range, then every record out of range.
  task automatic test_config_extremes();
    write_settings(8'h00, 8'hFF, 3'd0, -16'sd32768, 16'sd32767);
    run_random_segment(20);
    write_settings(8'hFF, 8'h00, 3'd7, 16'sd32767, -16'sd32768);
    run_random_segment(20);
  endtask

  task automatic test_random_settings();
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    repeat (3) begin
      lo = 16'($urandom_range(0, 8000));
      lo = lo - 16'sd6000;
      hi = 16'($urandom_range(2000, 12000));
      write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     3'($urandom_range(0, 7)), lo, hi);
      run_random_segment(15);
    end
  endtask

  // Store overflow: more records than fit, with trailing partial bytes.
  task automatic test_max_records();
    write_settings(8'h7E, 8'h7F, 3'd7, -16'sd4000, 16'sd8500);
    frame_body.push_back(8'd12);
    repeat (11) add_record(8'($urandom_range(0, 255)), pick_temp());
    frame_body.push_back(8'($urandom_range(0, 255)));
    frame_body.push_back(8'($urandom_range(0, 255)));
    send_frame(1'b0, 1'b0, -1);
    wait_idle();
  endtask

  // Receiver holds off while full frames keep coming, so the input stalls.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (4) begin
      frame_body.push_back(8'd8);
      repeat (8) add_record(8'($urandom_range(0, 255)), pick_temp());
      send_frame(1'b0, 1'b0, -1);
    end
    gaps_on = 1'b1;
    wait_idle();
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_cycle % 3 == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  // Compare each accepted output transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    frame_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
          $display("%0t: unexpected transaction, expected none, actual status=%b id=%h temp=%h",
                   $time, is_status, sensor_id, centi_temp);
        end
      end else begin
        want = expected_items.pop_front();
        check_field("is_status", want.is_status, is_status);
        check_field("sensor_id", want.sensor_id, sensor_id);
        check_field("centi_temp", want.centi_temp, centi_temp);
        check_field("out_of_range", want.out_of_range, out_of_range);
        check_field("frame_status", want.frame_status, frame_status);
        check_field("records_emitted", want.records_emitted, records_emitted);
        check_field("last", want.last_item, last);
      end
    end
  end

  // Test sequence.
  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_max_records();
    test_backpressure();
    wait_idle();
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
